// ===== rtl/core/q2e_pkg.sv =====
// shared constants, the atan table function and the lane type for the quaternion to euler angle converter
package q2e_pkg;

  localparam int TABLE_LEN = 24;
  // internal datapath width, holds normalized operands with cordic growth
  localparam int DW = 44;
  localparam int ZW = 33;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0: v = 33'sd843314856;
      1: v = 33'sd497837829;
      2: v = 33'sd263043836;
      3: v = 33'sd133525158;
      4: v = 33'sd67021686;
      5: v = 33'sd33543515;
      6: v = 33'sd16775850;
      7: v = 33'sd8388437;
      8: v = 33'sd4194282;
      9: v = 33'sd2097149;
      10: v = 33'sd1048575;
      11: v = 33'sd524287;
      12: v = 33'sd262143;
      13: v = 33'sd131071;
      14: v = 33'sd65535;
      15: v = 33'sd32767;
      16: v = 33'sd16383;
      17: v = 33'sd8191;
      18: v = 33'sd4095;
      19: v = 33'sd2047;
      20: v = 33'sd1023;
      21: v = 33'sd511;
      22: v = 33'sd255;
      23: v = 33'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // one lane of a cordic cell: operands and accumulated angle
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

endpackage

// ===== rtl/core/q2e_cordic_cell.sv =====
// one cordic vectoring micro-rotation stage, registered, three lanes
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic  clk,
  input  logic  en,
  input  lane_t lane_in [3],
  output lane_t lane_out [3]
);

  lane_t lane_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (lane_in[k].y > 0) begin
        lane_nxt[k].x = lane_in[k].x + (lane_in[k].y >>> SHIFT);
        lane_nxt[k].y = lane_in[k].y - (lane_in[k].x >>> SHIFT);
        lane_nxt[k].z = lane_in[k].z + atan_q30(SHIFT);
      end else begin
        lane_nxt[k].x = lane_in[k].x - (lane_in[k].y >>> SHIFT);
        lane_nxt[k].y = lane_in[k].y + (lane_in[k].x >>> SHIFT);
        lane_nxt[k].z = lane_in[k].z - atan_q30(SHIFT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_nxt;
    end
  end

endmodule

// ===== rtl/core/q2e_sqrt_cell.sv =====
// one step of a restoring square root, pipelined
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [56:0] rem_in,
  input  logic [28:0] root_in,
  output logic [56:0] rem_out,
  output logic [28:0] root_out
);

  // bit weight 2^(2*(28-STEP)) in the classic digit-by-digit form
  localparam int BP = 2 * (28 - STEP);

  logic [58:0] trial;
  logic [56:0] rem_nxt;
  logic [28:0] root_nxt;

  always_comb begin
    trial = ({30'b0, root_in} << (BP / 2 + 1)) | (59'd1 << BP);
    if ({2'b0, rem_in} >= trial) begin
      rem_nxt  = rem_in - trial[56:0];
      root_nxt = root_in | (29'd1 << (28 - STEP));
    end else begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_nxt;
      root_out <= root_nxt;
    end
  end

endmodule

// ===== rtl/core/quaternion_to_euler_angles_unit.sv =====
// top level: quaternion to roll, pitch and yaw converter
//
// Fully pipelined converter: one quaternion item is accepted per clock and a
// result item leaves every clock once the pipe is full, while the output is not
// stalled. The pipe is three product/sum stages, a 29-cell integer square
// root chain that forms the pitch cosine, one normalization stage, then a chain
// of CORDIC_STAGES (at most TABLE_LEN) vectoring cells that run roll, pitch
// and yaw side by side, and a rounding/saturation output register. The whole
// pipe advances only when the output register is free or being drained, so a
// stalled consumer holds every stage in place; no item is dropped. Inputs are
// raw Q1.14, angles are radians scaled by 2^ANGLE_FRAC_BITS.
module quaternion_to_euler_angles_unit import q2e_pkg::*; #(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_pitch_clamped
);

  localparam int NSTG = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int SQ   = 29;
  localparam int DEPTH = 3 + SQ + 1 + NSTG + 1;

  // whole pipe moves together
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // valid chain, one bit per stage
  logic [DEPTH-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[DEPTH-1];

  // stage 1: products
  logic signed [31:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r, p_zz_r, p_wy_r, p_zx_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx_r <= in_quat_w * in_quat_x;
      p_yz_r <= in_quat_y * in_quat_z;
      p_xx_r <= in_quat_x * in_quat_x;
      p_yy_r <= in_quat_y * in_quat_y;
      p_wz_r <= in_quat_w * in_quat_z;
      p_xy_r <= in_quat_x * in_quat_y;
      p_zz_r <= in_quat_z * in_quat_z;
      p_wy_r <= in_quat_w * in_quat_y;
      p_zx_r <= in_quat_z * in_quat_x;
    end
  end

  // stage 2: sines and cosines at 2^28 scale
  logic signed [34:0] sr_r, cr_r, sy_r, cy_r, sp_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sr_r <= 35'(2 * (36'(p_wx_r) + 36'(p_yz_r)));
      cr_r <= 35'((36'sd1 <<< 28) - 2 * (36'(p_xx_r) + 36'(p_yy_r)));
      sy_r <= 35'(2 * (36'(p_wz_r) + 36'(p_xy_r)));
      cy_r <= 35'((36'sd1 <<< 28) - 2 * (36'(p_yy_r) + 36'(p_zz_r)));
      sp_r <= 35'(2 * (36'(p_wy_r) - 36'(p_zx_r)));
    end
  end

  // stage 3: clamp test and 2^56 - s^2 (narrow when not clamped)
  logic               clamp3;
  logic [27:0]        ap;
  logic [34:0]        spabs;
  assign spabs  = sp_r[34] ? 35'(-sp_r) : sp_r;
  assign clamp3 = spabs >= 35'(1 << 28);
  assign ap     = spabs[27:0];

  logic signed [34:0] sr3_r, cr3_r, sy3_r, cy3_r, sp3_r;
  logic               cl3_r;
  logic [56:0]        rad_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sr3_r <= sr_r; cr3_r <= cr_r; sy3_r <= sy_r; cy3_r <= cy_r; sp3_r <= sp_r;
      cl3_r <= clamp3;
      rad_r <= (57'd1 << 56) - {29'd0, ap} * {29'd0, ap};
    end
  end

  // square root chain with delayed sideband
  logic [56:0] rem_w [SQ+1];
  logic [28:0] root_w [SQ+1];
  logic signed [34:0] sb_sr [SQ+1], sb_cr [SQ+1], sb_sy [SQ+1], sb_cy [SQ+1], sb_sp [SQ+1];
  logic               sb_cl [SQ+1];
  assign rem_w[0]  = rad_r;
  assign root_w[0] = '0;
  assign sb_sr[0] = sr3_r; assign sb_cr[0] = cr3_r; assign sb_sy[0] = sy3_r;
  assign sb_cy[0] = cy3_r; assign sb_sp[0] = sp3_r; assign sb_cl[0] = cl3_r;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    q2e_sqrt_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(adv),
      .rem_in(rem_w[g]), .root_in(root_w[g]),
      .rem_out(rem_w[g+1]), .root_out(root_w[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sb_sr[g+1] <= sb_sr[g]; sb_cr[g+1] <= sb_cr[g]; sb_sy[g+1] <= sb_sy[g];
        sb_cy[g+1] <= sb_cy[g]; sb_sp[g+1] <= sb_sp[g]; sb_cl[g+1] <= sb_cl[g];
      end
    end
  end

  // normalization: quadrant fold, scale up until max magnitude reaches 2^40
  function automatic lane_t prep(input logic signed [34:0] yi, input logic signed [34:0] xi);
    lane_t l;
    logic signed [DW-1:0] x, y, ax, ay, m;
    int sh;
    x = DW'(xi); y = DW'(yi); l.z = '0;
    if (xi < 0) begin
      if (yi >= 0) begin
        l.z = HALF_PI_Q30; x = DW'(yi); y = -DW'(xi);
      end else begin
        l.z = -HALF_PI_Q30; x = -DW'(yi); y = DW'(xi);
      end
    end
    ax = x[DW-1] ? -x : x;
    ay = y[DW-1] ? -y : y;
    m  = (ax > ay) ? ax : ay;
    sh = 0;
    for (int b = 0; b <= 40; b++) begin
      if (m[b]) sh = 40 - b;
    end
    if (m == 0) sh = 0;
    l.x = x <<< sh;
    l.y = y <<< sh;
    return l;
  endfunction

  lane_t lane_w [NSTG+1][3];
  logic  cl_w [NSTG+1];
  logic  sg_w [NSTG+1];
  logic [2:0] zero_w [NSTG+1];
  logic signed [34:0] cp;
  assign cp = 35'(root_w[SQ]);

  always_ff @(posedge clk) begin
    if (adv) begin
      lane_w[0][0] <= prep(sb_sr[SQ], sb_cr[SQ]);
      lane_w[0][1] <= prep(sb_sp[SQ], cp);
      lane_w[0][2] <= prep(sb_sy[SQ], sb_cy[SQ]);
      cl_w[0]      <= sb_cl[SQ];
      sg_w[0]      <= sb_sp[SQ] > 0;
      zero_w[0]    <= {sb_sy[SQ] == 0 && sb_cy[SQ] == 0,
                       sb_sp[SQ] == 0 && cp == 0,
                       sb_sr[SQ] == 0 && sb_cr[SQ] == 0};
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_cordic
    q2e_cordic_cell #(.SHIFT(s)) u_cell (
      .clk(clk), .en(adv), .lane_in(lane_w[s]), .lane_out(lane_w[s+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        cl_w[s+1] <= cl_w[s]; sg_w[s+1] <= sg_w[s]; zero_w[s+1] <= zero_w[s];
      end
    end
  end

  // rounding half up from 2^30 to 2^ANGLE_FRAC_BITS and saturation
  localparam int RS = 30 - ANGLE_FRAC_BITS;
  function automatic logic signed [15:0] rnd(input logic signed [ZW-1:0] a, input int w);
    logic signed [ZW:0] t;
    logic signed [ZW:0] hi, lo;
    t  = (ZW+1)'(a) + ((ZW+1)'(1) <<< (RS - 1));
    t  = t >>> RS;
    hi = ((ZW+1)'(1) <<< (w - 1)) - 1;
    lo = -((ZW+1)'(1) <<< (w - 1));
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[15:0];
  endfunction

  logic signed [ZW-1:0] za [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      za[k] = zero_w[NSTG][k] ? '0 : lane_w[NSTG][k].z;
    end
    if (cl_w[NSTG]) za[1] = sg_w[NSTG] ? HALF_PI_Q30 : -HALF_PI_Q30;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_roll_angle    <= rnd(za[0], 16);
      out_pitch_angle   <= 15'(rnd(za[1], 15));
      out_yaw_angle     <= rnd(za[2], 16);
      out_pitch_clamped <= cl_w[NSTG];
    end
  end

  // a stalled result must stay valid and hold its pitch angle
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pitch_angle) && out_valid)
    else $error("result changed under stall");
  // clamped pitch is always full scale
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_clamped |-> (out_pitch_angle > 15'sd0 ?
      out_pitch_angle == 15'(rnd(HALF_PI_Q30, 15)) :
      out_pitch_angle == 15'(rnd(-HALF_PI_Q30, 15))))
    else $error("clamped pitch not at pi/2");
  // ready follows the output register state
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipe stalled");

endmodule

// ===== dv/quaternion_to_euler_angles_unit_tb.sv =====
// testbench for the quaternion to euler angle converter, checked against an in-bench predictor
module quaternion_to_euler_angles_unit_tb;
  import q2e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES    = 16;
  localparam int FRAC      = 13;
  localparam int LATENCY   = 3 + 29 + 1 + STAGES + 1;
  localparam int N_RANDOM  = 1130;
  localparam longint UNIT_SQ = longint'(1) << 28;   // 1.0 for products of two components
  localparam longint NORM_TOP = longint'(1) << 40;
  localparam longint HALF_PI  = 64'sd1686629713;

  // one converted attitude
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               clamped;
  } euler_t;

  // one quaternion, with a typed-in answer where it is obvious
  typedef struct {
    logic signed [15:0] w, x, y, z;
    bit                 known;
    euler_t             answer;
  } quat_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_quat_w = '0;
  logic signed [15:0] in_quat_x = '0;
  logic signed [15:0] in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_roll_angle;
  logic signed [14:0] out_pitch_angle;
  logic signed [15:0] out_yaw_angle;
  logic               out_pitch_clamped;

  euler_t angles_pending[$];
  int     n_errors = 0;
  bit     steady = 1'b0;     // no idling on either side while set
  bit     feeding_done = 1'b0;

  quaternion_to_euler_angles_unit #(
    .CORDIC_STAGES(STAGES),
    .ANGLE_FRAC_BITS(FRAC)
  ) dut (.*);

  always #5 clk = ~clk;

  // atan table, radians scaled by 2^30, truncated
  function automatic longint arctan_step(input int i);
    longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                        262143, 131071, 65535, 32767, 16383, 8191,
                        4095, 2047, 1023, 511, 255, 127};
    return tbl[i];
  endfunction

  function automatic longint mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // vectoring cordic, result in radians scaled by 2^30
  function automatic longint cordic_atan2(input longint sy, input longint sx);
    longint acc, tmp, big;
    acc = 0;
    if (sx == 0 && sy == 0) return 0;
    if (sx < 0) begin
      tmp = sx;
      if (sy >= 0) begin
        sx = sy; sy = -tmp; acc = HALF_PI;
      end else begin
        sx = -sy; sy = tmp; acc = -HALF_PI;
      end
    end
    big = mag(sx) > mag(sy) ? mag(sx) : mag(sy);
    while (big < NORM_TOP) begin
      sx = sx * 2; sy = sy * 2; big = big * 2;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      tmp = sx;
      // >>> on longint is a floor shift
      if (sy > 0) begin
        sx = sx + (sy >>> i); sy = sy - (tmp >>> i); acc = acc + arctan_step(i);
      end else begin
        sx = sx - (sy >>> i); sy = sy + (tmp >>> i); acc = acc - arctan_step(i);
      end
    end
    return acc;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // round half up to output scale, then saturate to the field
  function automatic longint scale_angle(input longint a, input int width);
    longint r, hi;
    r = (a + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    hi = (longint'(1) << (width - 1)) - 1;
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r;
  endfunction

  function automatic euler_t predict_angles(input logic signed [15:0] qw,
                                            input logic signed [15:0] qx,
                                            input logic signed [15:0] qy,
                                            input logic signed [15:0] qz);
    longint w, x, y, z, s_roll, c_roll, s_yaw, c_yaw, s_pitch, pitch;
    euler_t e;
    w = qw; x = qx; y = qy; z = qz;
    s_roll  = 2 * (w * x + y * z);
    c_roll  = UNIT_SQ - 2 * (x * x + y * y);
    s_yaw   = 2 * (w * z + x * y);
    c_yaw   = UNIT_SQ - 2 * (y * y + z * z);
    s_pitch = 2 * (w * y - z * x);
    e.clamped = 1'b0;
    if (s_pitch >= UNIT_SQ || s_pitch <= -UNIT_SQ) begin
      // gimbal lock, pitch pinned to +-pi/2
      pitch = s_pitch > 0 ? HALF_PI : -HALF_PI;
      e.clamped = 1'b1;
    end else begin
      pitch = cordic_atan2(s_pitch,
                           int_sqrt((64'd1 << 56) - mag(s_pitch) * mag(s_pitch)));
    end
    e.roll  = 16'(scale_angle(cordic_atan2(s_roll, c_roll), 16));
    e.pitch = 15'(scale_angle(pitch, 15));
    e.yaw   = 16'(scale_angle(cordic_atan2(s_yaw, c_yaw), 16));
    return e;
  endfunction

  function automatic quat_row_t row(input int w, input int x, input int y, input int z);
    quat_row_t r;
    r.w = 16'(w); r.x = 16'(x); r.y = 16'(y); r.z = 16'(z);
    r.known = 1'b0;
    r.answer = '0;
    return r;
  endfunction

  function automatic quat_row_t row_ans(input int w, input int x, input int y, input int z,
                                        input int ro, input int pi, input int ya,
                                        input bit cl);
    quat_row_t r;
    r = row(w, x, y, z);
    r.known = 1'b1;
    r.answer.roll = 16'(ro); r.answer.pitch = 15'(pi);
    r.answer.yaw = 16'(ya); r.answer.clamped = cl;
    return r;
  endfunction

  // random quaternion: mostly near unit norm, some raw full-range noise
  function automatic quat_row_t random_quat();
    quat_row_t r;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      // build a rough unit quaternion by picking three parts and fitting the fourth
      int a, b, c, d, rest;
      a = $urandom_range(0, 16384) - 8192;
      b = $urandom_range(0, 16384) - 8192;
      c = $urandom_range(0, 16384) - 8192;
      rest = 16384 * 16384 - a * a - b * b - c * c;
      d = rest > 0 ? int'(int_sqrt(rest)) : 0;
      if ($urandom_range(0, 1)) d = -d;
      r = row(a, b, c, d);
      case ($urandom_range(0, 3))
        0: r = row(d, a, b, c);
        1: r = row(a, d, b, c);
        2: r = row(a, b, d, c);
        default: ;
      endcase
    end else if (sel < 8) begin
      r = row($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
              $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
    end else begin
      // every bit pattern, including values outside the nominal range
      r = row($urandom, $urandom, $urandom, $urandom);
    end
    return r;
  endfunction

  // valid drops only while idling, so items can follow back to back
  task automatic send_quat(input quat_row_t q);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_w <= q.w; in_quat_x <= q.x; in_quat_y <= q.y; in_quat_z <= q.z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (q.known) angles_pending = {angles_pending, q.answer};
    else angles_pending = {angles_pending, predict_angles(q.w, q.x, q.y, q.z)};
  endtask

  // receiver: random back-pressure, checks every accepted result
  always @(posedge clk) begin
    euler_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (angles_pending.size() == 0) begin
          $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d", $time,
                   out_roll_angle, out_pitch_angle, out_yaw_angle);
          n_errors++;
        end else begin
          want = angles_pending.pop_front();
          if (out_roll_angle !== want.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, want.roll, out_roll_angle);
            n_errors++;
          end
          if (out_pitch_angle !== want.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                     out_pitch_angle);
            n_errors++;
          end
          if (out_yaw_angle !== want.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, out_yaw_angle);
            n_errors++;
          end
          if (out_pitch_clamped !== want.clamped) begin
            $display("%0t: clamp expected %0b actual %0b", $time, want.clamped,
                     out_pitch_clamped);
            n_errors++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    quat_row_t directed[$];
    int waited;
    // identity, half turns, pitch near +-pi/2 both ways, gimbal lock, zero, extremes
    directed = {directed, row_ans(16384, 0, 0, 0, 0, 0, 0, 1'b0)};
    directed = {directed, row_ans(0, 0, 0, 0, 0, 0, 0, 1'b0)};
    directed = {directed, row(0, 16384, 0, 0)};
    directed = {directed, row(0, 0, 16384, 0)};
    directed = {directed, row(0, 0, 0, 16384)};
    directed = {directed, row(11585, 0, 11585, 0)};     // sine just under +1.0, pitch not pinned
    directed = {directed, row(11585, 0, -11585, 0)};    // sine just above -1.0
    directed = {directed, row(11585, 11585, 0, 0)};
    directed = {directed, row(11585, 0, 0, 11585)};
    directed = {directed, row(11585, 0, 11584, 0)};     // just under the clamp
    directed = {directed, row(-16384, 0, 0, 0)};
    directed = {directed, row(16384, 16384, 16384, 16384)};
    directed = {directed, row(-16384, -16384, -16384, -16384)};
    directed = {directed, row(32767, 32767, 32767, 32767)};
    directed = {directed, row(-32768, -32768, -32768, -32768)};
    directed = {directed, row(32767, -32768, 32767, -32768)};
    directed = {directed, row(0, 11585, 0, 11585)};     // roll and yaw sines zero, cosines just above zero
    directed = {directed, row(8192, 8192, 8192, 8192)};
    directed = {directed, row(1, -1, 1, -1)};
    directed = {directed, row(-21846, 5461, -10923, 13107)};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    steady = 1'b1;
    foreach (directed[i]) send_quat(directed[i]);
    in_valid <= 1'b0;
    steady = 1'b0;

    // hold off until the pipe has drained once
    while (angles_pending.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      steady = (n >= 400 && n < 550);
      send_quat(random_quat());
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    waited = 0;
    while (angles_pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0 && angles_pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/q2e_pkg.sv
rtl/core/q2e_cordic_cell.sv
rtl/core/q2e_sqrt_cell.sv
rtl/core/quaternion_to_euler_angles_unit.sv
dv/quaternion_to_euler_angles_unit_tb.sv
